[design/lpoq_pkg.sv]
`default_nettype none
package lpoq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  localparam int PAGE_W = 32;
  localparam int PID_W  = 16;
  localparam int KEY_W  = PAGE_W + PID_W;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TOUCH  = 1'b1
  } op_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PID_W-1:0]  pid;
  } key_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EV_RD  = 7'b0000010,
    ST_EV_CAP = 7'b0000100,
    ST_SEARCH = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_APPEND = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

[design/lpoq_if.sv]
`default_nettype none
// request word: one page reference
interface lpoq_req_if;
  logic                          valid;
  logic                          ready;
  lpoq_pkg::op_t                 operation;
  logic [lpoq_pkg::PAGE_W-1:0]   page_number;
  logic [lpoq_pkg::PID_W-1:0]    process_id;

  modport source (output valid, operation, page_number, process_id, input ready);
  modport sink   (input valid, operation, page_number, process_id, output ready);
endinterface

// response word: eviction and hit report
interface lpoq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          evicted;
  logic [lpoq_pkg::PAGE_W-1:0]   evicted_page;
  logic [lpoq_pkg::PID_W-1:0]    evicted_pid;
  logic                          hit;

  modport source (output valid, evicted, evicted_page, evicted_pid, hit, input ready);
  modport sink   (input valid, evicted, evicted_page, evicted_pid, hit, output ready);
endinterface
`default_nettype wire

[design/lpoq_ram.sv]
`default_nettype none
// simple dual-port RAM, registered read
module lpoq_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/lru_page_order_queue.sv]
`default_nettype none
// LRU page order queue. Holds up to capacity resident pages (page number plus
// process id) in one RAM, slot 0 least recent, slot occupancy-1 most recent.
// An insert word appends its key as most recent; when occupancy has reached
// the effective capacity (0 acts as 1, above DEPTH acts as DEPTH) it first
// evicts slot 0 and reports it. A touch word scans from slot 0 for the first
// equal key; on a hit that entry moves to most recent. Every request word
// gives exactly one response word. One word is processed at a time. Timing is
// set by the single RAM port pair and the slot-by-slot scan and shift. A
// stalled earlier response holds a finished word until the output register
// frees. A finished response waits in an output register while the next
// request is taken. Capacity may only be written while the queue is idle.
module lru_page_order_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lpoq_req_if.sink                           req,
  lpoq_rsp_if.source                         rsp,
  input  wire logic                          cfg_write_en,
  input  wire logic [lpoq_pkg::CAP_W-1:0]    cfg_write_data
);

  localparam int AW = lpoq_pkg::ADDR_W;
  localparam int OW = lpoq_pkg::OCC_W;

  lpoq_pkg::state_t state;

  logic [lpoq_pkg::CAP_W-1:0] capacity;
  logic [OW-1:0]              occ;    // resident entries
  logic [OW-1:0]              ridx;   // next slot to read in scan / shift
  logic                       rd_v;   // read issued last cycle
  logic [AW-1:0]              rd_addr;
  lpoq_pkg::key_t             key_q;
  logic                       ev_q;
  lpoq_pkg::key_t             ev_key;
  logic                       hit_q;

  // RAM port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [lpoq_pkg::KEY_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [lpoq_pkg::KEY_W-1:0]   ram_rdata;
  lpoq_pkg::key_t               rd_key;
  logic                         rd_issue;
  logic                         match;
  logic                         evict_now;
  logic [15:0]                  cap_eff;
  logic                         out_free;

  lpoq_ram #(
    .WIDTH  (lpoq_pkg::KEY_W),
    .DEPTH  (lpoq_pkg::DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key    = lpoq_pkg::key_t'(ram_rdata);
  assign match     = (rd_key == key_q);
  assign req.ready = (state == lpoq_pkg::ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = 16'd1;
    end else if (16'(capacity) > 16'(lpoq_pkg::DEPTH)) begin
      cap_eff = 16'(lpoq_pkg::DEPTH);
    end else begin
      cap_eff = 16'(capacity);
    end
  end

  assign evict_now = (occ != '0) && (16'(occ) >= cap_eff);

  // RAM access per state. Shift is pipelined: read slot ridx while writing the
  // slot read last cycle one place lower; the two never hit the same entry.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    ram_raddr = '0;
    rd_issue  = 1'b0;
    case (state)
      lpoq_pkg::ST_SEARCH: begin
        if (!(rd_v && match) && (ridx < occ)) begin
          rd_issue  = 1'b1;
          ram_raddr = ridx[AW-1:0];
        end
      end
      lpoq_pkg::ST_SHIFT: begin
        if (rd_v) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (ridx < occ) begin
          rd_issue  = 1'b1;
          ram_raddr = ridx[AW-1:0];
        end
      end
      lpoq_pkg::ST_APPEND: begin
        if (occ < OW'(lpoq_pkg::DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = occ[AW-1:0];
        end
      end
      default: begin
        ram_raddr = '0;   // slot 0 for eviction read
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpoq_pkg::ST_IDLE;
      occ       <= '0;
      capacity  <= lpoq_pkg::CAP_RESET;
      rd_v      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      // in DONE the output register is reloaded instead
      if (rsp.valid && rsp.ready && (state != lpoq_pkg::ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      rd_v    <= rd_issue;
      rd_addr <= ram_raddr;

      case (state)
        lpoq_pkg::ST_IDLE: begin
          if (req.valid) begin
            key_q  <= '{page: req.page_number, pid: req.process_id};
            ev_q   <= 1'b0;
            ev_key <= '0;
            hit_q  <= 1'b0;
            ridx   <= '0;
            if (req.operation == lpoq_pkg::OP_TOUCH) begin
              state <= lpoq_pkg::ST_SEARCH;
            end else if (evict_now) begin
              state <= lpoq_pkg::ST_EV_RD;
            end else begin
              state <= lpoq_pkg::ST_APPEND;
            end
          end
        end
        lpoq_pkg::ST_EV_RD: begin
          state <= lpoq_pkg::ST_EV_CAP;
        end
        lpoq_pkg::ST_EV_CAP: begin
          ev_q   <= 1'b1;
          ev_key <= rd_key;
          ridx   <= OW'(1);
          state  <= lpoq_pkg::ST_SHIFT;
        end
        lpoq_pkg::ST_SEARCH: begin
          if (rd_v && match) begin
            // hit: close the gap above it, then append as most recent
            hit_q <= 1'b1;
            ridx  <= OW'(rd_addr) + OW'(1);
            state <= lpoq_pkg::ST_SHIFT;
          end else if (!rd_v && (ridx >= occ)) begin
            state <= lpoq_pkg::ST_DONE;
          end else if (rd_issue) begin
            ridx <= ridx + OW'(1);
          end
        end
        lpoq_pkg::ST_SHIFT: begin
          if (rd_issue) begin
            ridx <= ridx + OW'(1);
          end
          if (!rd_v && (ridx >= occ)) begin
            occ   <= occ - OW'(1);
            state <= lpoq_pkg::ST_APPEND;
          end
        end
        lpoq_pkg::ST_APPEND: begin
          if (occ < OW'(lpoq_pkg::DEPTH)) begin
            occ <= occ + OW'(1);
          end
          state <= lpoq_pkg::ST_DONE;
        end
        lpoq_pkg::ST_DONE: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.evicted      <= ev_q;
            rsp.evicted_page <= ev_key.page;
            rsp.evicted_pid  <= ev_key.pid;
            rsp.hit          <= hit_q;
            state            <= lpoq_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lpoq_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/lpoq_checker.sv]
`default_nettype none
module lpoq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        evicted,
  input wire logic [31:0] evicted_page,
  input wire logic [15:0] evicted_pid,
  input wire logic        hit
);

  // response word holds while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(evicted) && $stable(hit)
      && $stable(evicted_page) && $stable(evicted_pid))
    else $error("response word changed while stalled");

  // evicted and hit are never both set in one response word
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(evicted && hit))
    else $error("evicted and hit both set");

  // no eviction means zero eviction payload
  a_ev_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted |-> evicted_page == 32'd0 && evicted_pid == 16'd0)
    else $error("eviction payload nonzero without eviction");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk)
    !rst && req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_rst: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_page_order_queue lpoq_checker u_lpoq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .evicted      (rsp.evicted),
  .evicted_page (rsp.evicted_page),
  .evicted_pid  (rsp.evicted_pid),
  .hit          (rsp.hit)
);
`default_nettype wire

[verif/tb_lru_page_order_queue.sv]
`default_nettype none
// Testbench for the LRU page order queue.
module tb_lru_page_order_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import lpoq_pkg::*;

  // Result word as the predictor and the scoreboard see it.
  typedef struct packed {
    logic              evicted;
    logic [PAGE_W-1:0] ev_page;
    logic [PID_W-1:0]  ev_pid;
    logic              hit;
  } lru_report_t;

  // One row of the directed table: the request word, plus a hand-written
  // expectation that replaces the predicted one when pinned is set.
  typedef struct packed {
    op_t         op;
    key_t        key;
    logic        pinned;
    lru_report_t report;
  } dir_row_t;

  localparam int          DIR_ROWS       = 14;
  localparam int          PHASES         = 8;
  localparam int          PHASE_WORDS    = 160;
  // Cycles with no handshake on either side before the run is declared hung.
  // Worst legal quiet stretch is a sender gap plus a full scan/shift plus a
  // receiver stall.
  localparam int          WATCHDOG_LIMIT = 2000;
  // Slowest word is a touch that scans and shifts all DEPTH slots.
  localparam int          DRAIN_CYCLES   = 2 * DEPTH + 10;

  localparam lru_report_t NO_EFFECT = '{1'b0, '0, '0, 1'b0};
  localparam lru_report_t HIT_ONLY  = '{1'b0, '0, '0, 1'b1};

  localparam key_t KEY_ZERO = '{32'h0000_0000, 16'h0000};
  localparam key_t KEY_ONES = '{32'hFFFF_FFFF, 16'hFFFF};
  localparam key_t KEY_A5   = '{32'hA5A5_A5A5, 16'h5A5A};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              cfg_write_en;
  logic [CAP_W-1:0]  cfg_write_data;

  lpoq_req_if req_if ();
  lpoq_rsp_if rsp_if ();

  lru_page_order_queue dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req_if),
    .rsp            (rsp_if),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of the recency stack and the capacity.
  // Slot 0 is least recent, slot resident-1 most recent.
  // ---------------------------------------------------------------------
  key_t             lru_keys [DEPTH];
  int               resident = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;

  lru_report_t      report_q [$];   // predicted results still owed by the dut
  int               mismatches = 0;
  int               quiet_cycles = 0;

  // Pinned expectation travels with the request word it belongs to.
  logic             pin_valid = 1'b0;
  lru_report_t      pin_report = '0;

  // Receiver stall pattern: one bit per cycle, rotated through 16 steps.
  logic [15:0]      stall_seed = 16'hFFFF;
  logic [3:0]       stall_step = 4'd0;
  logic             rsp_always_ready = 1'b1;

  dir_row_t         dir_tbl [DIR_ROWS];
  logic [CAP_W-1:0] cap_plan [PHASES];

  // Close the gap left by slot idx; entries above it move one slot down.
  task automatic drop_slot(input int idx);
    for (int i = idx; i + 1 < resident; i++)
      lru_keys[i] = lru_keys[i + 1];
    resident--;
  endtask

  // Apply one page reference to the predictor and return its report.
  task automatic apply_page_ref(input op_t op, input key_t k, output lru_report_t r);
    int lim;
    int hit_at;
    r = NO_EFFECT;
    // Capacity 0 behaves as 1, anything above DEPTH as DEPTH.
    lim = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg));
    if (op == OP_INSERT) begin
      // Only one victim per insert, even if capacity was lowered under
      // the current occupancy.
      if (resident >= lim && resident > 0) begin
        r.evicted = 1'b1;
        r.ev_page = lru_keys[0].page;
        r.ev_pid  = lru_keys[0].pid;
        drop_slot(0);
      end
      if (resident < DEPTH) begin
        lru_keys[resident] = k;
        resident++;
      end
    end else begin
      // First match from the least recent end wins (duplicates allowed).
      hit_at = -1;
      for (int i = 0; i < resident; i++)
        if (hit_at < 0 && lru_keys[i] == k) hit_at = i;
      if (hit_at >= 0) begin
        drop_slot(hit_at);
        lru_keys[resident] = k;
        resident++;
        r.hit = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: ready follows the stall pattern, or stays high.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    stall_step <= stall_step + 4'd1;
    rsp_if.ready <= rsp_always_ready | stall_seed[stall_step];
  end

  // ---------------------------------------------------------------------
  // Scoreboard and watchdog. Request acceptance is handled before the
  // result check so a word's prediction is queued first.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    lru_report_t predicted;
    lru_report_t want;
    lru_report_t seen;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        apply_page_ref(req_if.operation, '{req_if.page_number, req_if.process_id},
                       predicted);
        report_q.push_back(pin_valid ? pin_report : predicted);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen = '{rsp_if.evicted, rsp_if.evicted_page, rsp_if.evicted_pid, rsp_if.hit};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result word evicted=%0b page=%h pid=%h hit=%0b",
                   $time, seen.evicted, seen.ev_page, seen.ev_pid, seen.hit);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (seen.evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                     seen.evicted);
            mismatches++;
          end
          if (seen.ev_page !== want.ev_page) begin
            $display("%0t: evicted_page expected %h actual %h", $time, want.ev_page,
                     seen.ev_page);
            mismatches++;
          end
          if (seen.ev_pid !== want.ev_pid) begin
            $display("%0t: evicted_pid expected %h actual %h", $time, want.ev_pid,
                     seen.ev_pid);
            mismatches++;
          end
          if (seen.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, seen.hit);
            mismatches++;
          end
        end
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side. All inputs change on the falling edge.
  // ---------------------------------------------------------------------

  // Present one word and hold it until the dut takes it.
  task automatic send_word(input op_t op, input key_t k, input logic pinned,
                           input lru_report_t report);
    @(negedge clk);
    req_if.valid       = 1'b1;
    req_if.operation   = op;
    req_if.page_number = k.page;
    req_if.process_id  = k.pid;
    pin_valid          = pinned;
    pin_report         = report;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid for a number of cycles.
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    req_if.valid = 1'b0;
    pin_valid    = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Capacity changes only with the queue idle: no word in flight and every
  // owed result returned.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    pause_sender(1);
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_write_en   = 1'b1;
    cfg_write_data = value;
    @(posedge clk);
    capacity_reg = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // Random page reference, biased toward keys that are resident so touches
  // mostly hit and the shift paths get exercised.
  task automatic pick_page_ref(output op_t op, output key_t k);
    int roll;
    roll = $urandom_range(0, 99);
    k.page = $urandom;
    k.pid  = 16'($urandom_range(0, 65535));
    if (roll < 40) begin
      op = OP_INSERT;
      if (roll < 5) begin
        // narrow key space: collisions and duplicate entries
        k.page = 32'($urandom_range(0, 3));
        k.pid  = 16'($urandom_range(0, 1));
      end else if (roll < 9 && resident > 0) begin
        k = lru_keys[$urandom_range(0, resident - 1)];
      end
    end else begin
      op = OP_TOUCH;
      if (roll < 90 && resident > 0) begin
        k = lru_keys[$urandom_range(0, resident - 1)];
        // near miss: one bit off a resident key
        if (roll >= 80) k = key_t'(k ^ (48'd1 << $urandom_range(0, KEY_W - 1)));
      end
    end
  endtask

  initial begin
    op_t  op;
    key_t k;
    int   burst_left;
    logic gaps_on;

    req_if.valid       = 1'b0;
    req_if.operation   = OP_INSERT;
    req_if.page_number = '0;
    req_if.process_id  = '0;
    cfg_write_en       = 1'b0;
    cfg_write_data     = '0;

    // Directed walk at capacity 3. Comments show the stack, least recent
    // first, after each row.
    dir_tbl = '{
      '{OP_TOUCH,  KEY_ONES, 1'b1, NO_EFFECT},                    // empty: miss
      '{OP_INSERT, KEY_ZERO, 1'b1, NO_EFFECT},                    // Z
      '{OP_INSERT, KEY_ONES, 1'b1, NO_EFFECT},                    // Z F
      '{OP_INSERT, KEY_ZERO, 1'b1, NO_EFFECT},                    // Z F Z (dup)
      '{OP_TOUCH,  KEY_ZERO, 1'b1, HIT_ONLY},                     // F Z Z
      '{OP_TOUCH,  KEY_ZERO, 1'b1, HIT_ONLY},                     // F Z Z
      '{OP_TOUCH,  '{32'h0, 16'h1}, 1'b1, NO_EFFECT},             // pid differs
      '{OP_TOUCH,  '{32'h1, 16'h0}, 1'b1, NO_EFFECT},             // page differs
      '{OP_INSERT, KEY_A5,   1'b1, '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0}}, // Z Z A
      '{OP_TOUCH,  KEY_A5,   1'b1, HIT_ONLY},                     // most recent
      '{OP_INSERT, '{32'h1234_5678, 16'h1234}, 1'b1, '{1'b1, 32'h0, 16'h0, 1'b0}},
      '{OP_INSERT, '{32'h8765_4321, 16'h8765}, 1'b0, NO_EFFECT},
      '{OP_INSERT, '{32'h5A5A_5A5A, 16'hA5A5}, 1'b0, NO_EFFECT},
      '{OP_TOUCH,  '{32'h1234_5678, 16'h1234}, 1'b0, NO_EFFECT}
    };

    // Capacity per random phase: full depth, then dropped below occupancy,
    // zero, above depth, and a few in between.
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd7, 5'd0};
    cap_plan[PHASES - 1] = CAP_W'($urandom_range(0, 31));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_capacity(5'd3);
    foreach (dir_tbl[i])
      send_word(dir_tbl[i].op, dir_tbl[i].key, dir_tbl[i].pinned, dir_tbl[i].report);

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      // Every third phase runs flat out on both sides.
      gaps_on          = (p % 3 != 0);
      rsp_always_ready = !gaps_on;
      stall_seed       = 16'($urandom) | 16'h0001;
      burst_left       = $urandom_range(1, 8);
      repeat (PHASE_WORDS) begin
        pick_page_ref(op, k);
        send_word(op, k, 1'b0, NO_EFFECT);
        burst_left--;
        if (burst_left == 0) begin
          if (gaps_on) pause_sender($urandom_range(1, 6));
          burst_left = $urandom_range(1, 8);
        end
      end
    end

    pause_sender(1);
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
